[rtl/tpr_pkg.sv]
// Package with the shared types and constants of the tachometer block.
`timescale 1ns / 1ps

package tpr_pkg;

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PPR        = 2'd2;

    localparam int PERIOD_BITS  = 32;
    localparam int PPR_BITS     = 8;
    localparam int EDGES_BITS   = 32;
    localparam int TIMEOUT_BITS = 23;
    localparam int TMO_US_BITS  = 33;
    localparam int RPM_BITS     = 26;
    localparam int DIVISOR_BITS = PERIOD_BITS + PPR_BITS;
    localparam int STEP_BITS    = 5;

    localparam logic [PERIOD_BITS-1:0] MIN_PERIOD_RESET = 32'd100000;
    localparam logic [TMO_US_BITS-1:0] TIMEOUT_US_RESET = 33'd90000000;
    localparam logic [PPR_BITS-1:0]    PPR_RESET        = 8'd1;
    localparam logic [9:0]             US_PER_MS        = 10'd1000;
    localparam logic [RPM_BITS-1:0]    US_PER_MINUTE    = 26'd60000000;
    localparam logic [STEP_BITS-1:0]   DIV_LAST_STEP    = 5'(RPM_BITS - 1);

    localparam logic [1:0] STATUS_VALID      = 2'd0;
    localparam logic [1:0] STATUS_NO_READING = 2'd1;
    localparam logic [1:0] STATUS_STOPPED    = 2'd2;

    // One read request as the front hands it to the divider side.
    typedef struct packed {
        logic [PERIOD_BITS-1:0] period;
        logic [PPR_BITS-1:0]    ppr;
        logic [EDGES_BITS-1:0]  edges;
        logic [1:0]             status;
    } job_t;

endpackage

[rtl/tachometer_period_rpm.sv]
// Top level of the period-measuring tachometer with its assertions.
// Usage: the input side is a queue. Push an item with push high while full is low.
// An item with cmd low reports a falling edge of the shaft sensor at now_us; it
// yields no result. An item with cmd high asks for the speed and yields exactly
// one result: rpm, pulse_total and status, shown while empty is low and taken
// with pop. Configuration goes through cfg_we, cfg_index and cfg_data, one
// register per cycle, with the block idle.
// Flow: a read with a valid reading passes from the job queue to the divider,
// through the period product and the bit-serial divider (one quotient bit per
// cycle), and then loads the result register. A read with no reading or a
// stopped shaft skips the product and the divider. Edges are taken every cycle
// while full is low. Reads are served one at a time: the divider takes no new
// read until the result of the last one is loaded into the result register.
// Reset clears the edge history, the counters and the queues and restores the
// register defaults. When the receiver stalls, the result register holds, the
// divider waits with its answer, two further reads queue up, and then full rises.
`timescale 1ns / 1ps

module tachometer_period_rpm #(
    parameter int TIME_BITS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic                               cmd,
    input  logic [TIME_BITS-1:0]               now_us,
    output logic                               empty,
    input  logic                               pop,
    output logic [tpr_pkg::RPM_BITS-1:0]       rpm,
    output logic [tpr_pkg::EDGES_BITS-1:0]     pulse_total,
    output logic [1:0]                         status
);

    logic          accept;
    logic          job_push;
    tpr_pkg::job_t job_in;
    tpr_pkg::job_t job_out;
    logic          q_pop;
    logic          q_empty;

    // The job queue's full flag is the only input stall, and it holds back edges
    // as well as reads.
    assign accept = push && !full;

    tpr_front #(
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .cmd      (cmd),
        .now_us   (now_us),
        .job_push (job_push),
        .job      (job_in)
    );

    tpr_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (job_push),
        .din  (job_in),
        .pop  (q_pop),
        .dout (job_out),
        .full (full),
        .empty(q_empty)
    );

    tpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (job_out),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .rpm        (rpm),
        .pulse_total(pulse_total),
        .status     (status)
    );

    // An edge transaction must never create a job for the divider.
    a_edge_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cmd) |-> !job_push)
        else $error("edge transaction produced a read job");

    // Every accepted read must enter the job queue.
    a_read_job: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd) |-> job_push)
        else $error("read transaction was dropped");

    // A result without a valid reading carries a zero speed.
    a_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != tpr_pkg::STATUS_VALID) |-> rpm == '0)
        else $error("nonzero rpm with an invalid status");

    // Status never takes the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == tpr_pkg::STATUS_VALID
                 || status == tpr_pkg::STATUS_NO_READING
                 || status == tpr_pkg::STATUS_STOPPED))
        else $error("result status out of range");

endmodule

[rtl/tpr_front.sv]
// Front end: configuration registers, edge tracking and read classification.
`timescale 1ns / 1ps

module tpr_front #(
    parameter int TIME_BITS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               accept,
    input  logic                               cmd,
    input  logic [TIME_BITS-1:0]               now_us,
    output logic                               job_push,
    output tpr_pkg::job_t                      job
);

    logic [tpr_pkg::PERIOD_BITS-1:0] min_period_reg;
    logic [tpr_pkg::TMO_US_BITS-1:0] timeout_us_reg;
    logic [tpr_pkg::PPR_BITS-1:0]    ppr_reg;
    logic [TIME_BITS-1:0]            last_edge_reg;
    logic [tpr_pkg::PERIOD_BITS-1:0] period_reg;
    logic [tpr_pkg::EDGES_BITS-1:0]  edges_reg;
    logic                            armed_reg;

    logic [TIME_BITS-1:0]            gap;
    logic                            gap_long;
    logic                            edge_ok;
    logic [tpr_pkg::PPR_BITS-1:0]    ppr_wr;
    logic [tpr_pkg::TMO_US_BITS-1:0] timeout_us_wr;

    assign gap      = now_us - last_edge_reg;
    assign gap_long = |gap[TIME_BITS-1:tpr_pkg::PERIOD_BITS];
    assign edge_ok  = !armed_reg || gap >= TIME_BITS'(min_period_reg);

    // A pulses-per-revolution of zero behaves as one, so fold it here.
    assign ppr_wr = (cfg_data[tpr_pkg::PPR_BITS-1:0] == '0) ? tpr_pkg::PPR_RESET
                                                            : cfg_data[tpr_pkg::PPR_BITS-1:0];
    assign timeout_us_wr = tpr_pkg::TMO_US_BITS'(cfg_data[tpr_pkg::TIMEOUT_BITS-1:0])
                         * tpr_pkg::TMO_US_BITS'(tpr_pkg::US_PER_MS);

    always_comb
    begin
        job_push   = accept && cmd;
        job.period = period_reg;
        job.ppr    = ppr_reg;
        job.edges  = edges_reg;
        if (!armed_reg || period_reg == '0)
        begin
            job.status = tpr_pkg::STATUS_NO_READING;
        end
        else if (gap > TIME_BITS'(timeout_us_reg))
        begin
            job.status = tpr_pkg::STATUS_STOPPED;
        end
        else
        begin
            job.status = tpr_pkg::STATUS_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= tpr_pkg::MIN_PERIOD_RESET;
            timeout_us_reg <= tpr_pkg::TIMEOUT_US_RESET;
            ppr_reg        <= tpr_pkg::PPR_RESET;
            last_edge_reg  <= '0;
            period_reg     <= '0;
            edges_reg      <= '0;
            armed_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tpr_pkg::CFG_MIN_PERIOD: min_period_reg <= cfg_data;
                    tpr_pkg::CFG_TIMEOUT:    timeout_us_reg <= timeout_us_wr;
                    tpr_pkg::CFG_PPR:        ppr_reg        <= ppr_wr;
                    default:                 ;
                endcase
            end
            if (accept && !cmd && edge_ok)
            begin
                // The arming edge records its time and is counted; later edges also set the period.
                if (armed_reg)
                begin
                    period_reg <= gap_long ? '1 : gap[tpr_pkg::PERIOD_BITS-1:0];
                end
                last_edge_reg <= now_us;
                edges_reg     <= edges_reg + tpr_pkg::EDGES_BITS'(1);
                armed_reg     <= 1'b1;
            end
        end
    end

endmodule

[rtl/tpr_queue.sv]
// Two-entry queue of read jobs between the front end and the divider.
`timescale 1ns / 1ps

module tpr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tpr_pkg::job_t din,
    input  logic          pop,
    output tpr_pkg::job_t dout,
    output logic          full,
    output logic          empty
);

    tpr_pkg::job_t mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/tpr_back.sv]
// Back end: period product, serial speed divider and result register.
`timescale 1ns / 1ps

module tpr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  tpr_pkg::job_t                     q_job,
    output logic                              q_pop,
    input  logic                              pop,
    output logic                              empty,
    output logic [tpr_pkg::RPM_BITS-1:0]      rpm,
    output logic [tpr_pkg::EDGES_BITS-1:0]    pulse_total,
    output logic [1:0]                        status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t                            state_reg;
    tpr_pkg::job_t                     job_reg;
    logic [tpr_pkg::DIVISOR_BITS-1:0]  divisor_reg;
    logic [tpr_pkg::RPM_BITS-1:0]      rem_reg;
    logic [tpr_pkg::RPM_BITS-1:0]      quot_reg;
    logic [tpr_pkg::STEP_BITS-1:0]     step_reg;
    logic                              res_valid_reg;
    logic [tpr_pkg::RPM_BITS-1:0]      rpm_reg;
    logic [tpr_pkg::EDGES_BITS-1:0]    pulse_total_reg;
    logic [1:0]                        status_reg;

    logic [tpr_pkg::RPM_BITS:0]        trial;
    logic                              fits;
    logic                              res_free;

    // Restoring division: the dividend shifts out of the quotient register MSB first.
    assign trial    = {rem_reg, quot_reg[tpr_pkg::RPM_BITS-1]};
    assign fits     = tpr_pkg::DIVISOR_BITS'(trial) >= divisor_reg;
    assign res_free = !res_valid_reg || pop;
    assign q_pop    = state_reg == S_IDLE && !q_empty;

    assign empty       = !res_valid_reg;
    assign rpm         = rpm_reg;
    assign pulse_total = pulse_total_reg;
    assign status      = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            res_valid_reg   <= 1'b0;
            job_reg         <= '0;
            divisor_reg     <= '0;
            rem_reg         <= '0;
            quot_reg        <= '0;
            step_reg        <= '0;
            rpm_reg         <= '0;
            pulse_total_reg <= '0;
            status_reg      <= tpr_pkg::STATUS_VALID;
        end
        else
        begin
            if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg  <= q_job;
                        rem_reg  <= '0;
                        step_reg <= tpr_pkg::DIV_LAST_STEP;
                        if (q_job.status == tpr_pkg::STATUS_VALID)
                        begin
                            quot_reg  <= tpr_pkg::US_PER_MINUTE;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            quot_reg  <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_MUL:
                begin
                    divisor_reg <= tpr_pkg::DIVISOR_BITS'(job_reg.period)
                                 * tpr_pkg::DIVISOR_BITS'(job_reg.ppr);
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (fits)
                    begin
                        rem_reg <= tpr_pkg::RPM_BITS'(tpr_pkg::DIVISOR_BITS'(trial) - divisor_reg);
                    end
                    else
                    begin
                        rem_reg <= trial[tpr_pkg::RPM_BITS-1:0];
                    end
                    quot_reg <= {quot_reg[tpr_pkg::RPM_BITS-2:0], fits};
                    step_reg <= step_reg - tpr_pkg::STEP_BITS'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_free)
                    begin
                        rpm_reg         <= quot_reg;
                        pulse_total_reg <= job_reg.edges;
                        status_reg      <= job_reg.status;
                        res_valid_reg   <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
